// ----- hdl/ola_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ola_pkg
// Shared types and codes for the ordered list append/delete block.
// ----------------------------------------------------------------------------
package ola_pkg;

   localparam int VALUE_W  = 32;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 3;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_DUMP   = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_APPENDED  = 3'd0,
      STS_FULL      = 3'd1,
      STS_DELETED   = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_ELEMENT   = 3'd4,
      STS_EMPTY     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_APPEND = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      value_type   key;
   } cell_ctrl_type;

endpackage : ola_pkg
`default_nettype wire

// ----- hdl/ola_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ola_cell
// One list slot: holds a value, compares it with the key and takes the
// appended value, its neighbor's value or the head value as told.
// ----------------------------------------------------------------------------
module ola_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  wire                        clock,
   input  wire ola_pkg::cell_ctrl_type ctrl,
   input  wire  [CW-1:0]              fill,
   input  wire ola_pkg::value_type    head_value,
   input  wire ola_pkg::value_type    next_value,
   input  wire                        found_up,
   output ola_pkg::value_type         value,
   output logic                       found_down
);
   import ola_pkg::*;

   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   value_type value_ff;
   value_type value_in;
   logic      occupied;
   logic      match;

   assign occupied   = IDX_C < fill;
   assign match      = occupied && (value_ff == ctrl.key);
   assign found_down = found_up || match;
   assign value      = value_ff;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_APPEND: begin
            if (fill == IDX_C) value_in = ctrl.key;
         end
         CELL_DELETE: begin
            if (found_down) value_in = next_value;
         end
         CELL_ROTATE: begin
            if (IDX_C == fill - CW'(1)) value_in = head_value;
            else                        value_in = next_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule : ola_cell
`default_nettype wire

// ----- hdl/ordered_list_append_delete.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_append_delete
// Ordered store of up to DEPTH signed values with append, delete by value
// and dump.
//
// req channel: tuser carries the request kind (append, delete, dump), tdata
// the signed value. rsp channel: tuser carries the status, tdata the element
// value during a dump (zero otherwise), tlast marks the final response of a
// request.
// Append and delete complete in the accept cycle; their single response is
// registered at the accept. Every cell compares its value with the key at
// once and the cells behind the first match shift down by one.
// A dump first enters the dump state and then sends the stored elements in
// order (an empty list registers a single empty response at the accept); its
// first response is registered after the state change. The cell row rotates
// by one each cycle the output is free and the head cell feeds the output.
// A new request is taken once the previous one is finished and the output
// register is free or being emptied; request kind 3 is taken and dropped.
// Reset empties the list; cell contents are not cleared.
// A stalled receiver holds the output register and pauses any dump.
// ----------------------------------------------------------------------------
module ordered_list_append_delete #(
   parameter int DEPTH = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [ola_pkg::VALUE_W-1:0]    req_tdata,   // [31:0] value
   input  wire  [ola_pkg::REQ_W-1:0]      req_tuser,   // [1:0] req_type
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [ola_pkg::VALUE_W-1:0]    rsp_tdata,   // [31:0] item
   output logic [ola_pkg::STATUS_W-1:0]   rsp_tuser,   // [2:0] status
   output logic                           rsp_tlast
);
   import ola_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   value_type     rsp_item_ff, rsp_item_in;
   logic          rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   value_type     cell_value [DEPTH];
   logic          found      [DEPTH+1];
   logic          out_free;
   logic          accept;
   logic          dump_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign dump_last  = (idx_ff == fill_ff - CW'(1));
   assign found[0]   = 1'b0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      value_type next_value;
      if (g == DEPTH - 1) begin : g_end
         assign next_value = cell_value[g];
      end else begin : g_mid
         assign next_value = cell_value[g+1];
      end
      ola_cell #(
         .IDX (g),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .fill       (fill_ff),
         .head_value (cell_value[0]),
         .next_value (next_value),
         .found_up   (found[g]),
         .value      (cell_value[g]),
         .found_down (found[g+1])
      );
   end

   always_comb begin
      ctrl.op  = CELL_HOLD;
      ctrl.key = req_tdata;
      if (accept) begin
         case (req_kind_type'(req_tuser))
            REQ_APPEND: begin
               if (fill_ff != DEPTH_C) ctrl.op = CELL_APPEND;
            end
            REQ_DELETE: begin
               ctrl.op = CELL_DELETE;
            end
            default: begin
               ctrl.op = CELL_HOLD;
            end
         endcase
      end else if ((state_ff == S_DUMP) && out_free) begin
         ctrl.op = CELL_ROTATE;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_item_in = '0;
               rsp_last_in = 1'b1;
               case (req_kind_type'(req_tuser))
                  REQ_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (fill_ff == DEPTH_C) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        fill_in       = fill_ff + CW'(1);
                        rsp_status_in = STS_APPENDED;
                     end
                  end
                  REQ_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (found[DEPTH]) begin
                        fill_in       = fill_ff - CW'(1);
                        rsp_status_in = STS_DELETED;
                     end else begin
                        rsp_status_in = STS_NOT_FOUND;
                     end
                  end
                  REQ_DUMP: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_ELEMENT;
               rsp_item_in   = cell_value[0];
               rsp_last_in   = dump_last;
               idx_in        = idx_ff + CW'(1);
               if (dump_last) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule : ordered_list_append_delete
`default_nettype wire

// ----- test/ola_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ola_checker
// Request and response monitor for the ordered list append/delete block.
//
// Watches both stream channels, keeps its own copy of the stored list, works
// out the responses of every accepted request and compares each accepted
// response with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module ola_checker #(
   parameter int DEPTH = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   input  wire                           req_tready,
   input  wire  [ola_pkg::VALUE_W-1:0]   req_tdata,   // [31:0] value
   input  wire  [ola_pkg::REQ_W-1:0]     req_tuser,   // [1:0] req_type
   input  wire                           rsp_tvalid,
   input  wire                           rsp_tready,
   input  wire  [ola_pkg::VALUE_W-1:0]   rsp_tdata,   // [31:0] item
   input  wire  [ola_pkg::STATUS_W-1:0]  rsp_tuser,   // [2:0] status
   input  wire                           rsp_tlast,
   output int                            fail_count,
   output int                            outstanding
);
   import ola_pkg::*;

   typedef struct packed {
      status_type status;
      value_type  item;
      logic       last;
   } list_rsp_type;

   value_type    list_cells [DEPTH];
   int           list_fill;
   list_rsp_type rsp_q [$];
   int           errors = 0;

   function automatic void queue_rsp(status_type status, value_type item, logic last);
      rsp_q.push_back('{status: status, item: item, last: last});
   endfunction

   task automatic apply_request(input logic [REQ_W-1:0] kind, input value_type val);
      int hit;
      hit = -1;
      case (kind)
         REQ_APPEND: begin
            if (list_fill >= DEPTH) begin
               queue_rsp(STS_FULL, '0, 1'b1);
            end else begin
               list_cells[list_fill] = val;
               list_fill++;
               queue_rsp(STS_APPENDED, '0, 1'b1);
            end
         end
         REQ_DELETE: begin
            for (int i = 0; i < list_fill; i++)
               if (hit < 0 && list_cells[i] == val) hit = i;
            if (hit < 0) begin
               queue_rsp(STS_NOT_FOUND, '0, 1'b1);
            end else begin
               // close the gap behind the earliest match
               for (int i = hit; i < list_fill - 1; i++) list_cells[i] = list_cells[i + 1];
               list_fill--;
               queue_rsp(STS_DELETED, '0, 1'b1);
            end
         end
         REQ_DUMP: begin
            if (list_fill == 0) begin
               queue_rsp(STS_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < list_fill; i++)
                  queue_rsp(STS_ELEMENT, list_cells[i], i == list_fill - 1);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      list_rsp_type want;
      list_rsp_type got;
      if (reset) begin
         list_fill = 0;
         rsp_q.delete();
      end else begin
         // responses first: one accepted in this cycle belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: status_type'(rsp_tuser), item: rsp_tdata, last: rsp_tlast};
            if (rsp_q.size() == 0) begin
               errors++;
               $display("%0t: expected no response, actual status %0d item %h last %0b",
                        $time, got.status, got.item, got.last);
            end else begin
               want = rsp_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: expected status %0d item %h last %0b,",
                           $time, want.status, want.item, want.last,
                           " actual status %0d item %h last %0b",
                           got.status, got.item, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) apply_request(req_tuser, value_type'(req_tdata));
      end
      outstanding <= rsp_q.size();
      fail_count  <= errors;
   end

endmodule : ola_checker

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the ordered list append/delete block.
//
// Drives a short directed sequence (empty list, extreme values, duplicates,
// a full list, misses, the unused request kind) and then random requests
// that alternately grow and shrink the list, under three idle patterns on
// the two channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   import ola_pkg::*;

   localparam int DEPTH           = 16;
   localparam int ITEMS_PER_PHASE = 32;
   localparam int TREND_SPAN      = 24;
   localparam int QUIET_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 40;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [VALUE_W-1:0]   req_tdata;
   logic [REQ_W-1:0]     req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [VALUE_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]  rsp_tuser;
   logic                 rsp_tlast;
   int                   fail_count;
   int                   outstanding;
   int                   idle_pct;
   int                   stall_pct;
   int                   quiet_cycles = 0;
   int                   random_count;
   value_type            value_pool [8];

   ordered_list_append_delete #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ola_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ordered_list_append_delete: mismatch");
         $finish;
      end
   end

   task automatic send_request(input logic [REQ_W-1:0] kind, input value_type val);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic value_type pick_value();
      if ($urandom_range(99) < 75) return value_pool[$urandom_range(7)];
      return value_type'($urandom);
   endfunction

   // alternate growing and shrinking stretches so the list hits full and empty
   task automatic send_random(input int count);
      int sent;
      int roll;
      bit grow;
      logic [REQ_W-1:0] kind;
      sent = 0;
      while (sent < count) begin
         grow = ((random_count / TREND_SPAN) % 2) == 0;
         roll = $urandom_range(99);
         if (roll < 5) kind = REQ_UNUSED;
         else if (roll < 20) kind = REQ_DUMP;
         else if (roll < (grow ? 90 : 30)) kind = REQ_APPEND;
         else kind = REQ_DELETE;
         send_request(kind, pick_value());
         if (kind != REQ_UNUSED) begin
            sent++;
            random_count++;
         end
      end
   endtask

   initial begin
      value_type seed_vals [16];
      seed_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0001,
                    32'hFFFF_FFFE, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0001,
                    32'h0F0F_F0F0, 32'hF0F0_0F0F, 32'h0000_0000, 32'hC3A5_5A3C};
      value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     value_type'($urandom), value_type'($urandom),
                     value_type'($urandom), value_type'($urandom)};
      random_count = 0;
      idle_pct     = 26;
      stall_pct   <= 68;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(REQ_DUMP, 32'h0000_0000);
      send_request(REQ_DELETE, 32'h0000_0000);
      send_request(REQ_UNUSED, 32'hDEAD_BEEF);
      foreach (seed_vals[i]) send_request(REQ_APPEND, seed_vals[i]);
      send_request(REQ_APPEND, 32'h2468_ACE0);
      send_request(REQ_DUMP, 32'hFFFF_FFFF);
      // duplicates: only the earliest zero goes
      send_request(REQ_DELETE, 32'h0000_0000);
      send_request(REQ_DELETE, 32'h7FFF_FFFF);
      send_request(REQ_DUMP, 32'h0000_0000);
      send_request(REQ_DELETE, 32'h1357_9BDF);

      send_random(ITEMS_PER_PHASE);
      idle_pct   = 68;
      stall_pct <= 26;
      send_random(ITEMS_PER_PHASE);
      idle_pct   = 0;
      stall_pct <= 0;
      send_random(ITEMS_PER_PHASE);
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ordered_list_append_delete: match");
      end else begin
         $display("ordered_list_append_delete: mismatch");
      end
      $finish;
   end

endmodule : tb_top

// ----- ordered_list_append_delete.f -----
hdl/ola_pkg.sv
hdl/ola_cell.sv
hdl/ordered_list_append_delete.sv
test/ola_checker.sv
test/tb_top.sv
